@@ src/assert_macros.svh @@
// assertion macros shared by the escape encoder modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ECE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ECE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define ECE_ASSERT(lbl, prop, msg)
`define ECE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/ece_pkg.sv @@
// types, constants and the escape table of the escape encoder
// no dependencies
package ece_pkg;

    localparam logic [7:0] BSL     = 8'h5C;
    localparam logic [7:0] UND     = 8'h5F;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } t_out_item;

    // what the back end has to send for one item
    typedef enum logic [1:0] {
        K_NONE,
        K_PLAIN,
        K_ESC
    } t_kind;

    typedef struct packed {
        logic       lead_bsl;
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_B0,
        PH_B1,
        PH_B2
    } t_phase;

    // escape code 1..8, zero for a byte that passes through
    function automatic logic [3:0] esc_code(input logic [7:0] b);
        logic [3:0] c;
        unique case (b)
            8'h0A:   c = 4'd1;
            8'h0D:   c = 4'd2;
            8'h20:   c = 4'd3;
            8'h22:   c = 4'd4;
            8'h27:   c = 4'd5;
            8'h60:   c = 4'd6;
            8'h3A:   c = 4'd7;
            8'h3B:   c = 4'd8;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

endpackage

@@ src/ece_queue.sv @@
// small flip-flop queue of commands between front and back end
// depends on ece_pkg
`include "assert_macros.svh"
module ece_queue #(
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  ece_pkg::t_cmd i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output ece_pkg::t_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ece_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ECE_ASSERT(a_no_overflow, i_push |-> !o_full, "push into a full queue")

endmodule

@@ src/ece_front.sv @@
// front end: takes source bytes, tracks the held backslash, queues commands
// depends on ece_pkg
`include "assert_macros.svh"
module ece_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ece_pkg::t_in_item i_item,
    input  logic             i_full,
    output logic             o_push,
    output ece_pkg::t_cmd     o_cmd
);

    logic       r_held;
    logic       n_held;
    logic       w_accept;
    logic [3:0] w_code;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_code   = ece_pkg::esc_code(i_item.in_byte);

    always_comb begin
        o_cmd.lead_bsl = r_held && (i_item.in_byte != ece_pkg::UND);
        o_cmd.last     = i_item.in_last;
        o_cmd.kind     = ece_pkg::K_PLAIN;
        o_cmd.data     = i_item.in_byte;
        n_held         = 1'b0;
        priority if (r_held && (i_item.in_byte == ece_pkg::UND)) begin
            o_cmd.kind = ece_pkg::K_ESC;
            o_cmd.data = ece_pkg::CH_ZERO;
        end else if (i_item.in_byte == ece_pkg::BSL) begin
            // a backslash waits for the next byte unless the string ends here
            if (!i_item.in_last) begin
                o_cmd.kind = ece_pkg::K_NONE;
                n_held     = 1'b1;
            end
        end else if (w_code != 4'd0) begin
            o_cmd.kind = ece_pkg::K_ESC;
            o_cmd.data = ece_pkg::CH_ZERO + {4'd0, w_code};
        end else begin
            o_cmd.kind = ece_pkg::K_PLAIN;
        end
    end

    // an item that only starts holding a backslash sends nothing
    assign o_push = w_accept && !(o_cmd.kind == ece_pkg::K_NONE && !o_cmd.lead_bsl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (w_accept) begin
            r_held <= n_held;
        end
    end

    `ECE_ASSERT(a_held_clears, (w_accept && i_item.in_last) |=> !r_held, "held past string end")

endmodule

@@ src/ece_back.sv @@
// back end: expands one queued command into output bytes, one per cycle unless the output stalls
// depends on ece_pkg
`include "assert_macros.svh"
module ece_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  ece_pkg::t_cmd      i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ece_pkg::t_out_item o_item
);

    ece_pkg::t_phase    r_phase;
    ece_pkg::t_phase    n_phase;
    ece_pkg::t_phase    w_eff;
    ece_pkg::t_out_item r_out;
    logic               r_vld;
    logic               w_load;
    logic               w_final;
    logic [7:0]         w_byte;

    assign w_load = i_head_valid && (!r_vld || i_ready);
    assign o_pop  = w_load && w_final;

    // output selection for the current step
    always_comb begin
        w_eff = r_phase;
        if (r_phase == ece_pkg::PH_LEAD && !i_head.lead_bsl) begin
            w_eff = ece_pkg::PH_B0;
        end
        w_byte  = ece_pkg::BSL;
        w_final = 1'b0;
        unique case (w_eff)
            ece_pkg::PH_LEAD: begin
                w_final = (i_head.kind == ece_pkg::K_NONE);
            end
            ece_pkg::PH_B0: begin
                if (i_head.kind == ece_pkg::K_PLAIN) begin
                    w_byte  = i_head.data;
                    w_final = 1'b1;
                end
            end
            ece_pkg::PH_B1: begin
                w_byte = ece_pkg::UND;
            end
            ece_pkg::PH_B2: begin
                w_byte  = i_head.data;
                w_final = 1'b1;
            end
            default: begin
                w_byte  = ece_pkg::BSL;
                w_final = 1'b0;
            end
        endcase
    end

    // next step
    always_comb begin
        n_phase = r_phase;
        if (w_load) begin
            if (w_final) begin
                n_phase = ece_pkg::PH_LEAD;
            end else begin
                unique case (w_eff)
                    ece_pkg::PH_LEAD: n_phase = ece_pkg::PH_B0;
                    ece_pkg::PH_B0:   n_phase = ece_pkg::PH_B1;
                    ece_pkg::PH_B1:   n_phase = ece_pkg::PH_B2;
                    default:          n_phase = ece_pkg::PH_LEAD;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ece_pkg::PH_LEAD;
            r_vld   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_load) begin
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_byte   <= w_byte;
            r_out.run_last   <= w_final;
            r_out.string_end <= w_final && i_head.last;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_out;

    `ECE_ASSERT(a_head_mid_item, (r_phase != ece_pkg::PH_LEAD) |-> i_head_valid, "command left mid expansion")
    `ECE_ASSERT(a_end_is_run_last, o_valid |-> (!o_item.string_end || o_item.run_last), "string end off the last byte")
    `ECE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

@@ src/escape_char_encoder_unit.sv @@
// top level of the escape encoder: front end, command queue, back end
// depends on ece_pkg, ece_front, ece_queue, ece_back
//
//   channel  handshake          payload
//   input    i_valid / o_ready  i_item (in_byte, in_last)
//   output   o_valid / i_ready  o_item (out_byte, run_last, string_end)
//
// while the output takes them, the back end sends one byte per cycle: a plain
// byte gives 1 byte, an escaped one 3, a released backslash adds 1: up to 4 per item
// the front end takes an item per cycle while the queue has room
// an accepted item's command passes through the queue, its bytes through the output register
// synchronous active-low reset empties the queue and drops a held backslash
// either side may stall; the queue and output register decouple them
module escape_char_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ece_pkg::t_in_item  i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output ece_pkg::t_out_item o_item
);

    logic          w_full;
    logic          w_push;
    logic          w_pop;
    logic          w_head_valid;
    ece_pkg::t_cmd w_cmd;
    ece_pkg::t_cmd w_head;

    ece_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    ece_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    ece_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_item       (o_item)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench of escape_char_encoder_unit: directed and random strings, random stalls
// depends on ece_pkg and the encoder rtl
module testbench;

    localparam int unsigned SEND_IDLE [3] = '{14, 74, 0};
    localparam int unsigned RECV_IDLE [3] = '{74, 14, 0};
    localparam int unsigned RX_HOLD_CYCLES = 150;
    localparam int unsigned RANDOM_ITEMS = 88;
    localparam int unsigned PH1_START = 25;
    localparam int unsigned PH2_START = 55;
    localparam logic [7:0] ESC_CHARS [8] =
        '{8'h0A, 8'h0D, 8'h20, 8'h22, 8'h27, 8'h60, 8'h3A, 8'h3B};

    typedef struct {
        ece_pkg::t_in_item item;
        int unsigned       phase;
        bit                drain_first;
        bit                hold_rx;
    } t_send_entry;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    ece_pkg::t_in_item  i_item = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    ece_pkg::t_out_item o_item;

    t_send_entry        send_q [$];
    ece_pkg::t_out_item expected_bytes [$];
    bit                 bsl_held = 1'b0;
    int unsigned        cur_phase = 0;
    bit                 hold_req = 1'b0;
    int unsigned        hold_left = 0;
    bit                 results_drained = 1'b1;
    int unsigned        items_in = 0;
    int unsigned        error_count = 0;

    escape_char_encoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // output bytes that one accepted item is due to produce
    function automatic void predict_escape(input ece_pkg::t_in_item it);
        logic [7:0]         run [$];
        logic [7:0]         digit;
        ece_pkg::t_out_item r;
        run = {};
        digit = 8'h00;
        if (bsl_held && it.in_byte == ece_pkg::UND) begin
            bsl_held = 1'b0;
            run = {ece_pkg::BSL, ece_pkg::UND, ece_pkg::CH_ZERO};
        end else begin
            if (bsl_held) begin
                run.push_back(ece_pkg::BSL);
            end
            bsl_held = 1'b0;
            if (it.in_byte == ece_pkg::BSL) begin
                if (it.in_last) begin
                    run.push_back(ece_pkg::BSL);
                end else begin
                    bsl_held = 1'b1;
                end
            end else begin
                case (it.in_byte)
                    8'h0A:   digit = "1";
                    8'h0D:   digit = "2";
                    8'h20:   digit = "3";
                    8'h22:   digit = "4";
                    8'h27:   digit = "5";
                    8'h60:   digit = "6";
                    8'h3A:   digit = "7";
                    8'h3B:   digit = "8";
                    default: digit = 8'h00;
                endcase
                if (digit != 8'h00) begin
                    run.push_back(ece_pkg::BSL);
                    run.push_back(ece_pkg::UND);
                    run.push_back(digit);
                end else begin
                    run.push_back(it.in_byte);
                end
            end
        end
        foreach (run[k]) begin
            r.out_byte   = run[k];
            r.run_last   = (k == run.size() - 1);
            r.string_end = r.run_last && it.in_last;
            expected_bytes.push_back(r);
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last, input int unsigned ph,
                              input bit drain, input bit hold);
        t_send_entry e;
        e.item.in_byte = b;
        e.item.in_last = last;
        e.phase        = ph;
        e.drain_first  = drain;
        e.hold_rx      = hold;
        send_q.push_back(e);
    endtask

    // sender; an item that waits for the drain starts only once nothing is offered and all expected output has come
    always @(posedge i_clk) begin : drive_proc
        t_send_entry e;
        bit          req;
        req = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (send_q.size() != 0
                && !(send_q[0].drain_first && (i_valid || !results_drained))
                && $urandom_range(0, 99) >= SEND_IDLE[cur_phase]) begin
                e = send_q.pop_front();
                req = e.hold_rx;
                i_valid   <= 1'b1;
                i_item    <= e.item;
                cur_phase <= e.phase;
            end else begin
                i_valid <= 1'b0;
            end
        end
        hold_req <= req;
    end

    // receiver, with one long hold-off while the sender keeps offering
    always @(posedge i_clk) begin : ready_proc
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_left <= RX_HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= RECV_IDLE[cur_phase]);
        end
    end

    // checks each output item, then predicts from each accepted input item
    always @(posedge i_clk) begin : monitor_proc
        ece_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected output item, expected none, got %h",
                             $time, o_item);
                    error_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_item.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %h, got %h",
                                 $time, want.out_byte, o_item.out_byte);
                        error_count++;
                    end
                    if (o_item.run_last !== want.run_last) begin
                        $display("%0t: run_last expected %b, got %b",
                                 $time, want.run_last, o_item.run_last);
                        error_count++;
                    end
                    if (o_item.string_end !== want.string_end) begin
                        $display("%0t: string_end expected %b, got %b",
                                 $time, want.string_end, o_item.string_end);
                        error_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                predict_escape(i_item);
                items_in <= items_in + 1;
            end
            results_drained <= (expected_bytes.size() == 0);
        end
    end

    initial begin : stimulus
        int unsigned n_rand;
        int unsigned len;
        int unsigned ph;
        int unsigned prev_ph;
        int unsigned total_items;
        int unsigned pick;
        logic [7:0]  b;
        n_rand = 0;
        prev_ph = 0;

        // byte extremes
        queue_byte(8'h00, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b1, 0, 1'b0, 1'b0);
        // every escaped byte in one string
        foreach (ESC_CHARS[k]) begin
            queue_byte(ESC_CHARS[k], k == 7, 0, 1'b0, 1'b0);
        end
        // backslash underscore, backslash before an escaped byte, two backslashes and an underscore,
        // then a final backslash with nothing held
        queue_byte(ece_pkg::BSL, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::UND, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::BSL, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(8'h0A, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::BSL, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::BSL, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::UND, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::BSL, 1'b1, 0, 1'b0, 1'b0);
        // held backslash then a final backslash
        queue_byte(ece_pkg::BSL, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::BSL, 1'b1, 0, 1'b0, 1'b0);
        // lone underscore, backslash before a plain byte, lone final backslash
        queue_byte(ece_pkg::UND, 1'b1, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::BSL, 1'b0, 0, 1'b0, 1'b0);
        queue_byte(8'h41, 1'b1, 0, 1'b0, 1'b0);
        queue_byte(ece_pkg::BSL, 1'b1, 0, 1'b0, 1'b0);

        // random strings, heavy on backslashes, underscores and escaped bytes
        while (n_rand < RANDOM_ITEMS) begin
            ph = (n_rand >= PH2_START) ? 2 : (n_rand >= PH1_START) ? 1 : 0;
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    b = ece_pkg::BSL;
                end else if (pick < 40) begin
                    b = ece_pkg::UND;
                end else if (pick < 60) begin
                    b = ESC_CHARS[$urandom_range(0, 7)];
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                queue_byte(b, k == len - 1, ph,
                           k == 0 && ph == 1 && prev_ph != 1,
                           k == 0 && ph == 2 && prev_ph != 2);
                prev_ph = ph;
            end
            n_rand += len;
        end
        total_items = send_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_in != total_items) @(posedge i_clk);
        while (!results_drained) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (expected_bytes.size() != 0) begin
                $display("%0t: %0d expected output items never came, expected %h, got none",
                         $time, expected_bytes.size(), expected_bytes[0]);
            end
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("%0t: run did not finish", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/ece_pkg.sv
src/ece_queue.sv
src/ece_front.sv
src/ece_back.sv
src/escape_char_encoder_unit.sv
verif/testbench.sv
